[design/lpmf_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the length-prefixed message FIFO.
// No dependencies; every other design file imports this package.
package lpmf_pkg;

  localparam int LEN_W  = 12;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 3;
  localparam int ACT_W  = 2;
  localparam int NEED_W = LEN_W + 1;

  // Command queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [ACT_W-1:0] {
    OP_BEGIN_WR = 2'd0,
    OP_WR_BYTE  = 2'd1,
    OP_BEGIN_RD = 2'd2,
    OP_RD_BYTE  = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_TOO_SMALL = 3'd3,
    ST_SEQ       = 3'd4
  } status_e;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    op_e                op;
    logic [LEN_W-1:0]   length;
    logic [BYTE_W-1:0]  data;
    logic [LEN_W-1:0]   room;
    logic [NEED_W-1:0]  need;   // length plus header bytes
    logic               fits;   // length fits in the header
  } cmd_t;

endpackage

[design/lpmf_front.sv]
`timescale 1ns / 1ps
// Front end: takes requests, classifies them and stages them for the queue.
// Depends on lpmf_pkg.
module lpmf_front import lpmf_pkg::*; #(
  parameter int HEADER_BYTES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [LEN_W-1:0]  msg_length_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [LEN_W-1:0]  dest_room_i,
  output logic              push_o,
  output cmd_t              push_cmd_o,
  input  logic              q_full_i
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;

  assign busy   = valid_q && q_full_i;
  assign accept = start && !busy;
  assign push_o = valid_q && !q_full_i;
  assign push_cmd_o = cmd_q;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d       = 1'b1;
      cmd_d.op      = op_e'(action_i);
      cmd_d.length  = msg_length_i;
      cmd_d.data    = data_byte_i;
      cmd_d.room    = dest_room_i;
      cmd_d.need    = NEED_W'(msg_length_i) + NEED_W'(HEADER_BYTES);
      // A one-byte header only holds lengths below 256.
      cmd_d.fits    = (HEADER_BYTES >= 2) || (msg_length_i[LEN_W-1:BYTE_W] == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

[design/lpmf_cmd_queue.sv]
`timescale 1ns / 1ps
// Short request queue that decouples the front from the back.
// Depends on lpmf_pkg.
module lpmf_cmd_queue import lpmf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[design/lpmf_back.sv]
`timescale 1ns / 1ps
// Back end: ring memory, pointers, byte counters and the request sequencer.
// Depends on lpmf_pkg.
module lpmf_back import lpmf_pkg::*; #(
  parameter int RING_BYTES   = 4096,
  parameter int HEADER_BYTES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic [LEN_W-1:0]  length_out_o,
  output logic [BYTE_W-1:0] byte_out_o,
  output logic              last_o,
  output logic [LEN_W-1:0]  free_bytes_o,
  output logic [LEN_W-1:0]  used_bytes_o
);

  localparam int PW    = $clog2(RING_BYTES);
  localparam int HDR_W = 8 * HEADER_BYTES;
  localparam int CNT_W = $clog2(HEADER_BYTES + 1);
  localparam int CMP_W = (PW > NEED_W) ? PW : NEED_W;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_HDR_WR  = 4'b0010,
    S_HDR_RD  = 4'b0100,
    S_BYTE_RD = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [PW-1:0]       wp_q, wp_d, rp_q, rp_d, walk_q, walk_d;
  logic [PW-1:0]       free_q, free_d, used_q, used_d;
  logic [LEN_W-1:0]    wl_q, wl_d, rl_q, rl_d;
  logic                wr_open_q, wr_open_d, rd_open_q, rd_open_d;
  logic [NEED_W-1:0]   wr_need_q, wr_need_d;
  logic [LEN_W-1:0]    wr_sh_q, wr_sh_d;
  logic [LEN_W-1:0]    room_q, room_d;
  logic [HDR_W-1:0]    hdr_q, hdr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [LEN_W-1:0]    hdr_len;
  logic                done_q, done_d, last_q, last_d;
  status_e             status_q, status_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [BYTE_W-1:0]   byte_q, byte_d;

  logic [BYTE_W-1:0]   ring_mem [RING_BYTES];
  logic [BYTE_W-1:0]   rd_data_q;
  logic                mem_we;
  logic [PW-1:0]       mem_wa, mem_ra;
  logic [BYTE_W-1:0]   mem_wd;

  function automatic logic [PW-1:0] adv1(input logic [PW-1:0] p);
    return (p == PW'(RING_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign length_out_o = len_q;
  assign byte_out_o   = byte_q;
  assign last_o       = last_q;
  assign free_bytes_o = LEN_W'(free_q);
  assign used_bytes_o = LEN_W'(used_q);

  // Header bytes arrive low byte first; shift each in at the top.
  assign hdr_d   = (hdr_q >> 8) | (HDR_W'(rd_data_q) << (HDR_W - 8));
  assign hdr_len = LEN_W'(hdr_d);

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    walk_d    = walk_q;
    free_d    = free_q;
    used_d    = used_q;
    wl_d      = wl_q;
    rl_d      = rl_q;
    wr_open_d = wr_open_q;
    rd_open_d = rd_open_q;
    wr_need_d = wr_need_q;
    wr_sh_d   = wr_sh_q;
    room_d    = room_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    status_d  = ST_OK;
    len_d     = '0;
    byte_d    = '0;
    last_d    = 1'b0;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = wp_q;
    mem_wd    = head_i.data;
    mem_ra    = rp_q;

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (head_i.op)
            OP_BEGIN_WR: begin
              if (wr_open_q) begin
                done_d   = 1'b1;
                status_d = ST_SEQ;
              end else if (!head_i.fits ||
                           (CMP_W'(head_i.need) > CMP_W'(free_q))) begin
                done_d   = 1'b1;
                status_d = ST_NO_SPACE;
              end else begin
                wr_need_d = head_i.need;
                wr_sh_d   = head_i.length;
                cnt_d     = '0;
                state_d   = S_HDR_WR;
              end
            end
            OP_WR_BYTE: begin
              done_d = 1'b1;
              if (!wr_open_q) begin
                status_d = ST_SEQ;
              end else begin
                mem_we = 1'b1;
                wp_d   = adv1(wp_q);
                wl_d   = wl_q - 1'b1;
                if (wl_q == LEN_W'(1)) begin
                  wr_open_d = 1'b0;
                  used_d    = used_q + PW'(wr_need_q);
                  last_d    = 1'b1;
                end
              end
            end
            OP_BEGIN_RD: begin
              if (rd_open_q) begin
                done_d   = 1'b1;
                status_d = ST_SEQ;
              end else if (used_q < PW'(HEADER_BYTES)) begin
                done_d   = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                room_d  = head_i.room;
                walk_d  = rp_q;
                cnt_d   = '0;
                state_d = S_HDR_RD;
              end
            end
            OP_RD_BYTE: begin
              if (!rd_open_q) begin
                done_d   = 1'b1;
                status_d = ST_SEQ;
              end else begin
                state_d = S_BYTE_RD;
              end
            end
            default: begin
              done_d   = 1'b1;
              status_d = ST_SEQ;
            end
          endcase
        end
      end

      S_HDR_WR: begin
        mem_we  = 1'b1;
        mem_wd  = wr_sh_q[BYTE_W-1:0];
        wp_d    = adv1(wp_q);
        wr_sh_d = wr_sh_q >> 8;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(HEADER_BYTES - 1)) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          free_d  = free_q - PW'(wr_need_q);
          if (wr_need_q == NEED_W'(HEADER_BYTES)) begin
            // Empty message: commit the header at once.
            used_d = used_q + PW'(wr_need_q);
          end else begin
            wl_d      = LEN_W'(wr_need_q - NEED_W'(HEADER_BYTES));
            wr_open_d = 1'b1;
          end
        end
      end

      S_HDR_RD: begin
        mem_ra = walk_q;
        if (cnt_q != CNT_W'(HEADER_BYTES)) begin
          walk_d = adv1(walk_q);
          cnt_d  = cnt_q + 1'b1;
        end else begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          if (hdr_len == '0) begin
            // Empty record: drop its header and report empty.
            status_d = ST_EMPTY;
            rp_d     = walk_q;
            used_d   = used_q - PW'(HEADER_BYTES);
            free_d   = free_q + PW'(HEADER_BYTES);
          end else if (hdr_len > room_q) begin
            status_d = ST_TOO_SMALL;
            len_d    = hdr_len;
          end else begin
            len_d     = hdr_len;
            rp_d      = walk_q;
            rl_d      = hdr_len;
            rd_open_d = 1'b1;
            used_d    = used_q - PW'(HEADER_BYTES);
            free_d    = free_q + PW'(HEADER_BYTES);
          end
        end
      end

      S_BYTE_RD: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        byte_d  = rd_data_q;
        rp_d    = adv1(rp_q);
        rl_d    = rl_q - 1'b1;
        used_d  = used_q - 1'b1;
        free_d  = free_q + 1'b1;
        if (rl_q == LEN_W'(1)) begin
          rd_open_d = 1'b0;
          last_d    = 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      free_q    <= PW'(RING_BYTES - 1);
      used_q    <= '0;
      wl_q      <= '0;
      rl_q      <= '0;
      wr_open_q <= 1'b0;
      rd_open_q <= 1'b0;
      cnt_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      free_q    <= free_d;
      used_q    <= used_d;
      wl_q      <= wl_d;
      rl_q      <= rl_d;
      wr_open_q <= wr_open_d;
      rd_open_q <= rd_open_d;
      cnt_q     <= cnt_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q    <= walk_d;
    wr_need_q <= wr_need_d;
    wr_sh_q   <= wr_sh_d;
    room_q    <= room_d;
    status_q  <= status_d;
    len_q     <= len_d;
    byte_q    <= byte_d;
    last_q    <= last_d;
    if (state_q == S_HDR_RD && cnt_q != '0) begin
      hdr_q <= hdr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= ring_mem[mem_ra];
  end

endmodule

[design/length_prefixed_message_fifo.sv]
`timescale 1ns / 1ps
// Top level of the length-prefixed message FIFO: front, request queue, back.
// Depends on lpmf_pkg, lpmf_front, lpmf_cmd_queue and lpmf_back.
//
// Usage:
//   Drive action_i and its fields with start; a request is taken at a rising
//   edge where start is high and busy is low. Each request produces exactly
//   one result, shown for one cycle with done_o high; the receiver has no
//   way to hold results back, so it must take every strobe.
//   Begin write reserves header plus payload or answers no_space; write
//   bytes fill the message, which becomes readable after its last byte.
//   Begin read reports the head length (or empty / dest_too_small); read
//   bytes return the payload, last_o marks the final one.
//   free_bytes_o and used_bytes_o hold the counts after the request.
// Sequencing (H = HEADER_BYTES):
//   Results come out in request order. The back part runs one request at
//   a time over the single ring memory: a write byte stores its byte, a
//   granted begin write stores the H header bytes, a begin read that
//   reaches the header fetches its H bytes, and a granted read byte fetches
//   one payload byte. A two-entry queue lets the front keep taking requests.
// Reset: pointers, counters and open flags clear; the ring memory needs no
//   clearing, since only committed bytes are ever read.
module length_prefixed_message_fifo import lpmf_pkg::*; #(
  parameter int RING_BYTES   = 4096,
  parameter int HEADER_BYTES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [LEN_W-1:0]  msg_length_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [LEN_W-1:0]  dest_room_i,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic [LEN_W-1:0]  length_out_o,
  output logic [BYTE_W-1:0] byte_out_o,
  output logic              last_o,
  output logic [LEN_W-1:0]  free_bytes_o,
  output logic [LEN_W-1:0]  used_bytes_o
);

  logic push, q_full, q_empty, pop;
  cmd_t push_cmd, head_cmd;

  // Classify and stage each request.
  lpmf_front #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .msg_length_i (msg_length_i),
    .data_byte_i  (data_byte_i),
    .dest_room_i  (dest_room_i),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .q_full_i     (q_full)
  );

  // Hold requests while the back is still sequencing an earlier one.
  lpmf_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty)
  );

  // Carry out requests against the ring and report results.
  lpmf_back #(
    .RING_BYTES   (RING_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_cmd),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .done_o       (done_o),
    .status_o     (status_o),
    .length_out_o (length_out_o),
    .byte_out_o   (byte_out_o),
    .last_o       (last_o),
    .free_bytes_o (free_bytes_o),
    .used_bytes_o (used_bytes_o)
  );

endmodule

[design/lpmf_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the length-prefixed message FIFO, bound to the top.
// Depends on lpmf_pkg.
module lpmf_checker import lpmf_pkg::*; #(
  parameter int RING_BYTES = 4096
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              done_o,
  input logic [STAT_W-1:0] status_o,
  input logic [LEN_W-1:0]  length_out_o,
  input logic [BYTE_W-1:0] byte_out_o,
  input logic              last_o,
  input logic [LEN_W-1:0]  free_bytes_o,
  input logic [LEN_W-1:0]  used_bytes_o
);

  localparam logic SMALL_RING = (RING_BYTES <= 4096);

  // Free plus used bytes never exceed the ring less one byte.
  a_space_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && SMALL_RING) |->
      ((LEN_W + 1)'(free_bytes_o) + (LEN_W + 1)'(used_bytes_o) <=
       (LEN_W + 1)'(RING_BYTES - 1)))
    else $error("free plus used exceeds ring capacity");

  // A refused request returns no payload byte and no end mark.
  a_refused_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (!last_o && byte_out_o == '0))
    else $error("refused request carries data");

  // Only a header lookup reports a length.
  a_len_only_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_NO_SPACE || status_o == ST_EMPTY ||
                status_o == ST_SEQ)) |-> (length_out_o == '0))
    else $error("length reported on a request without header lookup");

  // A too-small answer always names a real message length.
  a_too_small_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_TOO_SMALL) |-> (length_out_o != '0))
    else $error("dest_too_small with zero length");

endmodule

bind length_prefixed_message_fifo lpmf_checker #(
  .RING_BYTES (RING_BYTES)
) u_lpmf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .done_o       (done_o),
  .status_o     (status_o),
  .length_out_o (length_out_o),
  .byte_out_o   (byte_out_o),
  .last_o       (last_o),
  .free_bytes_o (free_bytes_o),
  .used_bytes_o (used_bytes_o)
);
